// ----- rtl/core/mlfb_pkg.sv -----
// Shared types and constants for the monochrome LCD frame buffer engine.
// Holds command codes, register indexes, channel payload structs and FSM states.
// No dependencies.
package mlfb_pkg;

    localparam int ROWS_STORED    = 32;
    localparam int PAGES_PER_HALF = 8;
    localparam int PAGE_BITS      = 16;

    localparam int WORD_W = 16;

    // command codes carried in the kind field
    localparam logic [3:0] KIND_WR_PIX  = 4'd0;
    localparam logic [3:0] KIND_RD_PIX  = 4'd1;
    localparam logic [3:0] KIND_TG_PIX  = 4'd2;
    localparam logic [3:0] KIND_WR_WORD = 4'd3;
    localparam logic [3:0] KIND_RD_WORD = 4'd4;
    localparam logic [3:0] KIND_XOR_WRD = 4'd5;
    localparam logic [3:0] KIND_FILL    = 4'd6;
    localparam logic [3:0] KIND_INVERT  = 4'd7;
    localparam logic [3:0] KIND_PNT_WRD = 4'd8;
    localparam logic [3:0] KIND_PNT_ROW = 4'd9;

    // configuration register indexes
    localparam logic [1:0] CFG_GRAPHIC_ON = 2'd0;
    localparam logic [1:0] CFG_EXT_MODE   = 2'd1;
    localparam logic [1:0] CFG_GFX_MASK   = 2'd2;

    localparam logic [7:0] EXT_MODE_RST = 8'd52;
    localparam logic [7:0] GFX_MASK_RST = 8'd2;

    // address flag on controller address bytes
    localparam logic [7:0] BUS_ADDR_FLAG = 8'h80;
    localparam logic [7:0] BYTE_MASK     = 8'hff;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  x_coord;
        logic [6:0]  y_coord;
        logic [3:0]  page_col;
        logic        lit;
        logic [15:0] word_value;
    } t_cmd;

    typedef struct packed {
        logic        bus_valid;
        logic        register_select;
        logic [7:0]  bus_byte;
        logic [15:0] read_value;
        logic        ok;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [1:0] reg_index;
        logic [7:0] wdata;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_RMW,
        ST_RESULT,
        ST_WORD_OUT,
        ST_FILL,
        ST_INV_RD,
        ST_INV_WR,
        ST_ROW_HDR,
        ST_ROW_RD,
        ST_ROW_HI,
        ST_ROW_LO
    } t_state;

endpackage

// ----- rtl/core/mlfb_stream_if.sv -----
// Valid/ready channel used for commands, results and register writes.
// Payload type is set per instance; no other dependencies.
interface mlfb_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/mono_lcd_framebuffer_engine.sv -----
// Top level of the monochrome LCD frame buffer engine.
// Depends on mlfb_pkg, mlfb_stream_if and mlfb_ram.
// Channels: i_cmd takes command items (kind, coordinates, lit, word_value);
//   o_res gives one or more result items per command, the final one with last,
//   bus results carrying a command or data byte; i_cfg takes register writes
//   (index, data), always ready, to be written only while idle.
// Timing: pixel and word commands do one read and at most one write of the frame
//   store, passing from decode through read-modify-write to the result; a
//   reject goes from decode straight to result. Paint word instead sends its
//   five bytes at one per cycle while the output register is free. Paint row
//   reads each word and sends its two bytes before reading the next. Fill and
//   invert use the single write port walking every word, invert reading each
//   word before writing it. Commands are handled one at a time; the next is
//   taken once the final result sits in the output register.
// Reset: a clearing pass writes zero to every word; no command is taken
//   meanwhile, register writes are.
// Stalls: a result waits in the output register while o_res.ready is low; the
//   engine stops at its next result until the register frees up.
module mono_lcd_framebuffer_engine #(
    parameter int ROWS_STORED    = mlfb_pkg::ROWS_STORED,
    parameter int PAGES_PER_HALF = mlfb_pkg::PAGES_PER_HALF,
    parameter int PAGE_BITS      = mlfb_pkg::PAGE_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mlfb_stream_if.sink   i_cmd,
    mlfb_stream_if.source o_res,
    mlfb_stream_if.sink   i_cfg
);
    localparam int LINE_WORDS   = 2 * PAGES_PER_HALF;
    localparam int DEPTH        = ROWS_STORED * LINE_WORDS;
    localparam int AW           = $clog2(DEPTH);
    localparam int CW           = $clog2(LINE_WORDS);
    localparam int FRAME_WIDTH  = PAGES_PER_HALF * PAGE_BITS;
    localparam int FRAME_HEIGHT = 2 * ROWS_STORED;
    localparam int WW           = mlfb_pkg::WORD_W;
    // reciprocal for the column divide; exact for 8-bit x and PAGE_BITS <= 16
    localparam int RECIP        = (2**16 + PAGE_BITS - 1) / PAGE_BITS;
    localparam int RECIP_W      = $clog2(RECIP + 1);
    localparam int PW           = 8 + RECIP_W;

    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] LAST_COL  = CW'(LINE_WORDS - 1);

    // ---------------- registers ----------------
    mlfb_pkg::t_state r_state, n_state;
    mlfb_pkg::t_cmd   r_cmd, n_cmd;
    mlfb_pkg::t_res   r_res, n_res;
    logic             r_res_valid, n_res_valid;
    logic [7:0]       r_q, n_q;
    logic [AW-1:0]    r_ptr, n_ptr;
    logic [AW-1:0]    r_addr, n_addr;
    logic [WW-1:0]    r_mask, n_mask;
    logic [7:0]       r_row, n_row;
    logic [7:0]       r_vcol, n_vcol;
    logic [WW-1:0]    r_word, n_word;
    logic [WW-1:0]    r_rd, n_rd;
    logic             r_ok, n_ok;
    logic [2:0]       r_cnt, n_cnt;
    logic [CW-1:0]    r_wcnt, n_wcnt;

    logic             r_graphic_on;
    logic [7:0]       r_ext_mode;
    logic [7:0]       r_gfx_mask;

    // ---------------- memory port ----------------
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [WW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [WW-1:0] mem_rdata;

    mlfb_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (WW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // ---------------- decode helpers ----------------
    logic [PW-1:0] q_prod;
    logic [7:0]    rem;
    logic [3:0]    bit_idx;
    logic [WW-1:0] pix_mask;
    logic          y_hi;
    int            line_i;
    int            col_i;
    logic          is_pix;
    logic          pix_ok;
    logic          word_ok;
    logic [AW-1:0] fold_addr;
    logic [AW-1:0] row_base;
    logic [7:0]    mode_byte;
    logic          out_free;
    logic [WW-1:0] new_word;

    assign q_prod = PW'(i_cmd.data.x_coord) * PW'(RECIP);

    assign rem       = r_cmd.x_coord - 8'(int'(r_q) * PAGE_BITS);
    assign bit_idx   = 4'(PAGE_BITS - 1 - int'(rem));
    assign pix_mask  = WW'(1) << bit_idx;
    assign y_hi      = int'(r_cmd.y_coord) >= ROWS_STORED;
    assign line_i    = y_hi ? int'(r_cmd.y_coord) - ROWS_STORED : int'(r_cmd.y_coord);
    assign is_pix    = (r_cmd.kind == mlfb_pkg::KIND_WR_PIX) ||
                       (r_cmd.kind == mlfb_pkg::KIND_RD_PIX) ||
                       (r_cmd.kind == mlfb_pkg::KIND_TG_PIX);
    assign col_i     = (is_pix ? int'(r_q) : int'(r_cmd.page_col)) +
                       (y_hi ? PAGES_PER_HALF : 0);
    assign fold_addr = AW'(LINE_WORDS * line_i + col_i);
    assign row_base  = AW'(LINE_WORDS * int'(r_cmd.y_coord));
    assign pix_ok    = (int'(r_cmd.x_coord) < FRAME_WIDTH) &&
                       (int'(r_cmd.y_coord) < FRAME_HEIGHT);
    assign word_ok   = (int'(r_cmd.page_col) < PAGES_PER_HALF) &&
                       (int'(r_cmd.y_coord) < FRAME_HEIGHT);

    assign mode_byte = r_ext_mode | (r_graphic_on ? r_gfx_mask : 8'd0);
    assign out_free  = !r_res_valid || o_res.ready;

    assign i_cmd.ready = (r_state == mlfb_pkg::ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_res_valid;
    assign o_res.data  = r_res;

    // ---------------- next state ----------------
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_q         = r_q;
        n_ptr       = r_ptr;
        n_addr      = r_addr;
        n_mask      = r_mask;
        n_row       = r_row;
        n_vcol      = r_vcol;
        n_word      = r_word;
        n_rd        = r_rd;
        n_ok        = r_ok;
        n_cnt       = r_cnt;
        n_wcnt      = r_wcnt;
        n_res       = r_res;
        n_res_valid = r_res_valid && !o_res.ready;
        mem_we      = 1'b0;
        mem_waddr   = r_ptr;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = r_ptr;
        new_word    = mem_rdata;

        unique case (r_state)
            mlfb_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
                n_ptr  = r_ptr + AW'(1);
                if (r_ptr == LAST_ADDR) begin
                    n_state = mlfb_pkg::ST_IDLE;
                end
            end

            mlfb_pkg::ST_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd   = i_cmd.data;
                    n_q     = 8'(q_prod >> 16);
                    n_state = mlfb_pkg::ST_DECODE;
                end
            end

            mlfb_pkg::ST_DECODE: begin
                n_rd  = '0;
                n_ok  = 1'b0;
                n_ptr = '0;
                unique case (r_cmd.kind) inside
                    mlfb_pkg::KIND_WR_PIX, mlfb_pkg::KIND_RD_PIX,
                    mlfb_pkg::KIND_TG_PIX: begin
                        if (pix_ok) begin
                            mem_re    = 1'b1;
                            mem_raddr = fold_addr;
                            n_addr    = fold_addr;
                            n_mask    = pix_mask;
                            n_state   = mlfb_pkg::ST_RMW;
                        end else begin
                            n_state = mlfb_pkg::ST_RESULT;
                        end
                    end
                    mlfb_pkg::KIND_WR_WORD, mlfb_pkg::KIND_RD_WORD,
                    mlfb_pkg::KIND_XOR_WRD, mlfb_pkg::KIND_PNT_WRD: begin
                        if (word_ok) begin
                            mem_re    = 1'b1;
                            mem_raddr = fold_addr;
                            n_addr    = fold_addr;
                            n_row     = 8'(line_i);
                            n_vcol    = 8'(col_i);
                            n_state   = mlfb_pkg::ST_RMW;
                        end else begin
                            n_state = mlfb_pkg::ST_RESULT;
                        end
                    end
                    mlfb_pkg::KIND_FILL: begin
                        n_state = mlfb_pkg::ST_FILL;
                    end
                    mlfb_pkg::KIND_INVERT: begin
                        n_state = mlfb_pkg::ST_INV_RD;
                    end
                    mlfb_pkg::KIND_PNT_ROW: begin
                        if (int'(r_cmd.y_coord) < ROWS_STORED) begin
                            n_ptr   = row_base;
                            n_cnt   = (r_cmd.y_coord == 7'd0) ? 3'd0 : 3'd1;
                            n_wcnt  = '0;
                            n_state = mlfb_pkg::ST_ROW_HDR;
                        end else begin
                            n_state = mlfb_pkg::ST_RESULT;
                        end
                    end
                    default: begin
                        n_state = mlfb_pkg::ST_RESULT;
                    end
                endcase
            end

            mlfb_pkg::ST_RMW: begin
                mem_waddr = r_addr;
                n_ok      = 1'b1;
                n_rd      = '0;
                n_state   = mlfb_pkg::ST_RESULT;
                unique case (r_cmd.kind) inside
                    mlfb_pkg::KIND_WR_PIX: begin
                        new_word = r_cmd.lit ? (mem_rdata | r_mask) : (mem_rdata & ~r_mask);
                        mem_we   = 1'b1;
                    end
                    mlfb_pkg::KIND_RD_PIX: begin
                        n_rd = WW'(|(mem_rdata & r_mask));
                    end
                    mlfb_pkg::KIND_TG_PIX: begin
                        new_word = mem_rdata ^ r_mask;
                        mem_we   = 1'b1;
                    end
                    mlfb_pkg::KIND_WR_WORD: begin
                        new_word = r_cmd.word_value;
                        mem_we   = 1'b1;
                    end
                    mlfb_pkg::KIND_RD_WORD: begin
                        n_rd = mem_rdata;
                    end
                    mlfb_pkg::KIND_XOR_WRD: begin
                        new_word = mem_rdata ^ r_cmd.word_value;
                        mem_we   = 1'b1;
                    end
                    default: begin
                        // paint word
                        n_word  = mem_rdata;
                        n_cnt   = '0;
                        n_state = mlfb_pkg::ST_WORD_OUT;
                    end
                endcase
                mem_wdata = new_word;
            end

            mlfb_pkg::ST_RESULT: begin
                if (out_free) begin
                    n_res       = '0;
                    n_res.read_value = r_rd;
                    n_res.ok    = r_ok;
                    n_res.last  = 1'b1;
                    n_res_valid = 1'b1;
                    n_state     = mlfb_pkg::ST_IDLE;
                end
            end

            mlfb_pkg::ST_WORD_OUT: begin
                if (out_free) begin
                    n_res           = '0;
                    n_res.bus_valid = 1'b1;
                    n_res.ok        = 1'b1;
                    n_res_valid     = 1'b1;
                    n_cnt           = r_cnt + 3'd1;
                    case (r_cnt)
                        3'd0:    n_res.bus_byte = mode_byte;
                        3'd1:    n_res.bus_byte = mlfb_pkg::BUS_ADDR_FLAG | r_row;
                        3'd2:    n_res.bus_byte = mlfb_pkg::BUS_ADDR_FLAG | r_vcol;
                        3'd3: begin
                            n_res.register_select = 1'b1;
                            n_res.bus_byte        = r_word[15:8];
                        end
                        default: begin
                            n_res.register_select = 1'b1;
                            n_res.bus_byte        = r_word[7:0] & mlfb_pkg::BYTE_MASK;
                            n_res.last            = 1'b1;
                            n_state               = mlfb_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            mlfb_pkg::ST_FILL: begin
                mem_we    = 1'b1;
                mem_wdata = r_cmd.lit ? '1 : '0;
                n_ptr     = r_ptr + AW'(1);
                if (r_ptr == LAST_ADDR) begin
                    n_ok    = 1'b1;
                    n_state = mlfb_pkg::ST_RESULT;
                end
            end

            mlfb_pkg::ST_INV_RD: begin
                mem_re  = 1'b1;
                n_state = mlfb_pkg::ST_INV_WR;
            end

            mlfb_pkg::ST_INV_WR: begin
                mem_we    = 1'b1;
                mem_wdata = ~mem_rdata;
                n_ptr     = r_ptr + AW'(1);
                if (r_ptr == LAST_ADDR) begin
                    n_ok    = 1'b1;
                    n_state = mlfb_pkg::ST_RESULT;
                end else begin
                    n_state = mlfb_pkg::ST_INV_RD;
                end
            end

            mlfb_pkg::ST_ROW_HDR: begin
                if (out_free) begin
                    n_res           = '0;
                    n_res.bus_valid = 1'b1;
                    n_res.ok        = 1'b1;
                    n_res_valid     = 1'b1;
                    n_cnt           = r_cnt + 3'd1;
                    case (r_cnt)
                        3'd0:    n_res.bus_byte = mode_byte;
                        3'd1:    n_res.bus_byte = mlfb_pkg::BUS_ADDR_FLAG | {1'b0, r_cmd.y_coord};
                        default: begin
                            n_res.bus_byte = mlfb_pkg::BUS_ADDR_FLAG;
                            n_state        = mlfb_pkg::ST_ROW_RD;
                        end
                    endcase
                end
            end

            mlfb_pkg::ST_ROW_RD: begin
                mem_re  = 1'b1;
                n_state = mlfb_pkg::ST_ROW_HI;
            end

            mlfb_pkg::ST_ROW_HI: begin
                if (out_free) begin
                    n_res                 = '0;
                    n_res.bus_valid       = 1'b1;
                    n_res.register_select = 1'b1;
                    n_res.bus_byte        = mem_rdata[15:8];
                    n_res.ok              = 1'b1;
                    n_res_valid           = 1'b1;
                    n_state               = mlfb_pkg::ST_ROW_LO;
                end
            end

            mlfb_pkg::ST_ROW_LO: begin
                if (out_free) begin
                    n_res                 = '0;
                    n_res.bus_valid       = 1'b1;
                    n_res.register_select = 1'b1;
                    n_res.bus_byte        = mem_rdata[7:0];
                    n_res.ok              = 1'b1;
                    n_res.last            = (r_wcnt == LAST_COL);
                    n_res_valid           = 1'b1;
                    n_ptr                 = r_ptr + AW'(1);
                    n_wcnt                = r_wcnt + CW'(1);
                    n_state               = (r_wcnt == LAST_COL) ? mlfb_pkg::ST_IDLE
                                                                 : mlfb_pkg::ST_ROW_RD;
                end
            end

            default: begin
                n_state = mlfb_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- state registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mlfb_pkg::ST_CLEAR;
            r_ptr       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_q    <= n_q;
        r_addr <= n_addr;
        r_mask <= n_mask;
        r_row  <= n_row;
        r_vcol <= n_vcol;
        r_word <= n_word;
        r_rd   <= n_rd;
        r_ok   <= n_ok;
        r_cnt  <= n_cnt;
        r_wcnt <= n_wcnt;
        r_res  <= n_res;
    end

    // ---------------- configuration registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_graphic_on <= 1'b0;
            r_ext_mode   <= mlfb_pkg::EXT_MODE_RST;
            r_gfx_mask   <= mlfb_pkg::GFX_MASK_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.reg_index)
                mlfb_pkg::CFG_GRAPHIC_ON: r_graphic_on <= i_cfg.data.wdata[0];
                mlfb_pkg::CFG_EXT_MODE:   r_ext_mode   <= i_cfg.data.wdata;
                mlfb_pkg::CFG_GFX_MASK:   r_gfx_mask   <= i_cfg.data.wdata;
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    // the clearing pass produces no results
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mlfb_pkg::ST_CLEAR) |-> !r_res_valid)
        else $error("result pending during clearing pass");

    // bus bytes never carry read data and are never rejects
    a_bus_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.bus_valid) |-> (r_res.ok && r_res.read_value == '0))
        else $error("bus result with read data or ok low");

    // no frame write while waiting for a command
    a_idle_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mlfb_pkg::ST_IDLE) |-> !mem_we)
        else $error("frame write in idle");

    // an accepted command is decoded in the next cycle
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> (r_state == mlfb_pkg::ST_DECODE))
        else $error("accepted item not decoded");
`endif

endmodule

// ----- rtl/core/mlfb_ram.sv -----
// Frame word store: one write port, one read port, registered read data.
// Read data holds while no read is issued. No dependencies.
module mlfb_ram #(
    parameter int DEPTH = 512,
    parameter int AW    = 9,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
